// ----- rtl/qsm_pkg.sv -----
package qsm_pkg;

  // defaults for the top-level parameters
  localparam int MODULE_ID_BITS_DEF   = 8;
  localparam int PARAM_ID_BITS_DEF    = 8;
  localparam int PARAM_VALUE_BITS_DEF = 32;
  localparam int SAMPLE_WORD_BITS_DEF = 16;
  localparam int SAMPLE_INT_BITS_DEF  = 4;

  localparam int WORD_BITS = 64;
  localparam int CFG_BITS  = 8;
  localparam int REG_BITS  = 32;
  localparam logic [CFG_BITS-1:0] OWN_ID_RESET = 8'd2;

  // depth of the queue between front and back
  localparam int Q_DEPTH = 2;

  // parameter ids inside a header word
  localparam int PID_DATA_LENGTH  = 0;
  localparam int PID_ORDER        = 1;
  localparam int PID_SYMBOL_COUNT = 2;

  // supported constellation orders
  localparam logic [REG_BITS-1:0] ORDER_QAM16 = 32'd16;
  localparam logic [REG_BITS-1:0] ORDER_QPSK  = 32'd4;

  // what the back end does with a queued beat
  localparam logic [1:0] OP_FWD   = 2'd0;
  localparam logic [1:0] OP_QAM16 = 2'd1;
  localparam logic [1:0] OP_QPSK  = 2'd2;
  localparam logic [1:0] OP_HOLD  = 2'd3;

  // 3-bit signed constellation levels
  localparam logic signed [2:0] LVL_M3 = -3'sd3;
  localparam logic signed [2:0] LVL_M1 = -3'sd1;
  localparam logic signed [2:0] LVL_P1 = 3'sd1;
  localparam logic signed [2:0] LVL_P3 = 3'sd3;

  typedef struct packed {
    logic [1:0]           op;
    logic [WORD_BITS-1:0] word;
  } entry_t;

endpackage

// ----- rtl/qsm_front.sv -----
// Header parsing, parameter registers and data-phase word counting.
module qsm_front #(
  parameter int MODULE_ID_BITS   = qsm_pkg::MODULE_ID_BITS_DEF,
  parameter int PARAM_ID_BITS    = qsm_pkg::PARAM_ID_BITS_DEF,
  parameter int PARAM_VALUE_BITS = qsm_pkg::PARAM_VALUE_BITS_DEF
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             in_valid,
  output logic                             in_ready,
  input  logic [qsm_pkg::WORD_BITS-1:0]    in_word,
  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  logic [qsm_pkg::CFG_BITS-1:0]     cfg_data,
  input  logic                             q_full,
  output logic                             q_push,
  output qsm_pkg::entry_t                  q_entry
);

  localparam int ID_SHIFT = PARAM_ID_BITS + PARAM_VALUE_BITS;
  localparam logic [qsm_pkg::WORD_BITS-1:0] END_MARK =
    (64'd1 << MODULE_ID_BITS) - 64'd1;

  logic [qsm_pkg::CFG_BITS-1:0] own_module_id;
  logic                         in_data_phase;
  logic [qsm_pkg::REG_BITS-1:0] data_length;
  logic [qsm_pkg::REG_BITS-1:0] modulation_order;
  logic [qsm_pkg::REG_BITS-1:0] symbol_count;
  // nested down-counters: words left in this block, blocks left
  logic [qsm_pkg::REG_BITS-1:0] inner_left;
  logic [qsm_pkg::REG_BITS-1:0] outer_left;

  logic                         accept;
  logic [qsm_pkg::WORD_BITS-1:0] mod_id;
  logic [PARAM_ID_BITS-1:0]     pid;
  logic [qsm_pkg::REG_BITS-1:0] val;
  logic                         is_own;
  logic                         is_end;
  logic [qsm_pkg::REG_BITS-1:0] len_eff;
  logic [qsm_pkg::REG_BITS-1:0] cnt_eff;

  assign cfg_ready = 1'b1;
  assign in_ready  = !q_full;
  assign accept    = in_valid && in_ready;

  // split the header word
  assign mod_id = in_word >> ID_SHIFT;
  assign pid    = in_word[PARAM_VALUE_BITS +: PARAM_ID_BITS];
  assign val    = qsm_pkg::REG_BITS'(in_word[PARAM_VALUE_BITS-1:0]);
  assign is_own = mod_id == qsm_pkg::WORD_BITS'(own_module_id);
  assign is_end = mod_id == END_MARK;

  // length and count as they stand after this word's own write
  always_comb begin
    len_eff = data_length;
    cnt_eff = symbol_count;
    if (is_own && pid == PARAM_ID_BITS'(qsm_pkg::PID_DATA_LENGTH)) len_eff = val;
    if (is_own && pid == PARAM_ID_BITS'(qsm_pkg::PID_SYMBOL_COUNT)) cnt_eff = val;
  end

  // queue push: forwarded header words and all data words
  always_comb begin
    q_push        = accept && (in_data_phase || !is_own);
    q_entry.word  = in_word;
    q_entry.op    = qsm_pkg::OP_FWD;
    if (in_data_phase) begin
      if (modulation_order == qsm_pkg::ORDER_QAM16) q_entry.op = qsm_pkg::OP_QAM16;
      else if (modulation_order == qsm_pkg::ORDER_QPSK) q_entry.op = qsm_pkg::OP_QPSK;
      else q_entry.op = qsm_pkg::OP_HOLD;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      own_module_id    <= qsm_pkg::OWN_ID_RESET;
      in_data_phase    <= 1'b0;
      data_length      <= '0;
      modulation_order <= '0;
      symbol_count     <= '0;
      inner_left       <= '0;
      outer_left       <= '0;
    end else begin
      if (cfg_valid && cfg_ready) own_module_id <= cfg_data;
      if (accept) begin
        if (!in_data_phase) begin
          // parameter words; other ids (pilot width too) have no effect
          if (is_own) begin
            if (pid == PARAM_ID_BITS'(qsm_pkg::PID_DATA_LENGTH)) data_length <= val;
            if (pid == PARAM_ID_BITS'(qsm_pkg::PID_ORDER)) modulation_order <= val;
            if (pid == PARAM_ID_BITS'(qsm_pkg::PID_SYMBOL_COUNT)) symbol_count <= val;
          end
          if (is_end) begin
            in_data_phase <= (len_eff != '0) && (cnt_eff != '0);
            inner_left    <= len_eff;
            outer_left    <= cnt_eff;
          end
        end else begin
          // count down length * count data words
          if (inner_left == qsm_pkg::REG_BITS'(1)) begin
            if (outer_left == qsm_pkg::REG_BITS'(1)) begin
              in_data_phase <= 1'b0;
            end else begin
              outer_left <= outer_left - qsm_pkg::REG_BITS'(1);
              inner_left <= data_length;
            end
          end else begin
            inner_left <= inner_left - qsm_pkg::REG_BITS'(1);
          end
        end
      end
    end
  end

endmodule

// ----- rtl/qsm_queue.sv -----
// Small register FIFO between front and back.
module qsm_queue (
  input  logic            clk,
  input  logic            rst,
  input  logic            push,
  input  qsm_pkg::entry_t push_entry,
  output logic            full,
  input  logic            pop,
  output logic            head_valid,
  output qsm_pkg::entry_t head_entry
);

  localparam int PW = (qsm_pkg::Q_DEPTH > 1) ? $clog2(qsm_pkg::Q_DEPTH) : 1;
  localparam int CW = $clog2(qsm_pkg::Q_DEPTH + 1);
  localparam logic [PW-1:0] LAST = PW'(qsm_pkg::Q_DEPTH - 1);

  qsm_pkg::entry_t entries [qsm_pkg::Q_DEPTH];
  logic [PW-1:0] wr_ptr;
  logic [PW-1:0] rd_ptr;
  logic [CW-1:0] count;

  assign full       = count == CW'(qsm_pkg::Q_DEPTH);
  assign head_valid = count != '0;
  assign head_entry = entries[rd_ptr];

  // payload storage
  always_ff @(posedge clk) begin
    if (push) entries[wr_ptr] <= push_entry;
  end

  // pointers and fill level
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) wr_ptr <= (wr_ptr == LAST) ? '0 : wr_ptr + PW'(1);
      if (pop)  rd_ptr <= (rd_ptr == LAST) ? '0 : rd_ptr + PW'(1);
      if (push && !pop) count <= count + CW'(1);
      else if (pop && !push) count <= count - CW'(1);
    end
  end

endmodule

// ----- rtl/qsm_back.sv -----
// Symbol mapping and the output register.
module qsm_back #(
  parameter int SAMPLE_WORD_BITS = qsm_pkg::SAMPLE_WORD_BITS_DEF,
  parameter int SAMPLE_INT_BITS  = qsm_pkg::SAMPLE_INT_BITS_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          q_valid,
  input  qsm_pkg::entry_t               q_entry,
  output logic                          q_pop,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [qsm_pkg::WORD_BITS-1:0] out_word,
  output logic                          is_forwarded
);

  localparam int FRAC = SAMPLE_WORD_BITS - SAMPLE_INT_BITS;
  localparam int SHL  = (FRAC >= 0) ? FRAC : 0;
  localparam int SHR  = (FRAC < 0) ? -FRAC : 0;

  logic signed [2:0] last_real_level;
  logic signed [2:0] last_imag_level;
  logic signed [2:0] real_next;
  logic signed [2:0] imag_next;
  logic [qsm_pkg::WORD_BITS-1:0] sym_word;

  // level to fixed point; negative fraction bits floor via arithmetic shift
  function automatic logic [SAMPLE_WORD_BITS-1:0] to_fixed(input logic signed [2:0] v);
    logic signed [qsm_pkg::WORD_BITS-1:0] ext;
    ext = {{(qsm_pkg::WORD_BITS-3){v[2]}}, v};
    ext = (ext <<< SHL) >>> SHR;
    return ext[SAMPLE_WORD_BITS-1:0];
  endfunction

  assign q_pop = q_valid && (!out_valid || out_ready);

  // Gray-coded levels; unsupported order keeps the last point
  always_comb begin
    real_next = last_real_level;
    imag_next = last_imag_level;
    case (q_entry.op)
      qsm_pkg::OP_QAM16: begin
        case (q_entry.word[1:0])
          2'd0:    imag_next = qsm_pkg::LVL_M3;
          2'd1:    imag_next = qsm_pkg::LVL_M1;
          2'd2:    imag_next = qsm_pkg::LVL_P3;
          default: imag_next = qsm_pkg::LVL_P1;
        endcase
        if (q_entry.word[63:2] == 62'd0) real_next = qsm_pkg::LVL_M3;
        else if (q_entry.word[63:2] == 62'd1) real_next = qsm_pkg::LVL_M1;
        else if (q_entry.word[63:2] == 62'd2) real_next = qsm_pkg::LVL_P3;
        else real_next = qsm_pkg::LVL_P1;
      end
      qsm_pkg::OP_QPSK: begin
        imag_next = q_entry.word[0] ? qsm_pkg::LVL_P1 : qsm_pkg::LVL_M1;
        real_next = (q_entry.word[63:1] == 63'd0) ? qsm_pkg::LVL_M1 : qsm_pkg::LVL_P1;
      end
      default: begin
        real_next = last_real_level;
        imag_next = last_imag_level;
      end
    endcase
  end

  // real at bit 32, imaginary at bit 0
  assign sym_word = (qsm_pkg::WORD_BITS'(to_fixed(real_next)) << 32)
                  | qsm_pkg::WORD_BITS'(to_fixed(imag_next));

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid       <= 1'b0;
      last_real_level <= '0;
      last_imag_level <= '0;
    end else begin
      if (q_pop) begin
        out_valid <= 1'b1;
        if (q_entry.op != qsm_pkg::OP_FWD) begin
          last_real_level <= real_next;
          last_imag_level <= imag_next;
        end
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // output payload
  always_ff @(posedge clk) begin
    if (q_pop) begin
      is_forwarded <= q_entry.op == qsm_pkg::OP_FWD;
      out_word     <= (q_entry.op == qsm_pkg::OP_FWD) ? q_entry.word : sym_word;
    end
  end

endmodule

// ----- rtl/qam_symbol_mapper_with_param_header.sv -----
// A word accepted at the input is written into the queue and then registered in the output register.
// Throughput: one word per cycle; input ready drops only when the two-entry queue is full.
// Header words for this module are absorbed and produce no output beat.
// Reset (synchronous, active high): header phase, all parameters and counters zero,
// own module id 2, queue and output register empty. No clearing pass.
module qam_symbol_mapper_with_param_header #(
  parameter int MODULE_ID_BITS   = qsm_pkg::MODULE_ID_BITS_DEF,
  parameter int PARAM_ID_BITS    = qsm_pkg::PARAM_ID_BITS_DEF,
  parameter int PARAM_VALUE_BITS = qsm_pkg::PARAM_VALUE_BITS_DEF,
  parameter int SAMPLE_WORD_BITS = qsm_pkg::SAMPLE_WORD_BITS_DEF,
  parameter int SAMPLE_INT_BITS  = qsm_pkg::SAMPLE_INT_BITS_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [qsm_pkg::WORD_BITS-1:0] in_word,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [qsm_pkg::WORD_BITS-1:0] out_word,
  output logic                          is_forwarded,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [qsm_pkg::CFG_BITS-1:0]  cfg_data
);

  logic            q_full;
  logic            q_push;
  logic            q_pop;
  logic            q_valid;
  qsm_pkg::entry_t push_entry;
  qsm_pkg::entry_t head_entry;

  // header parsing and counting
  qsm_front #(
    .MODULE_ID_BITS  (MODULE_ID_BITS),
    .PARAM_ID_BITS   (PARAM_ID_BITS),
    .PARAM_VALUE_BITS(PARAM_VALUE_BITS)
  ) u_front (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_word  (in_word),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_data (cfg_data),
    .q_full   (q_full),
    .q_push   (q_push),
    .q_entry  (push_entry)
  );

  // decoupling queue
  qsm_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (q_push),
    .push_entry(push_entry),
    .full      (q_full),
    .pop       (q_pop),
    .head_valid(q_valid),
    .head_entry(head_entry)
  );

  // mapping and output register
  qsm_back #(
    .SAMPLE_WORD_BITS(SAMPLE_WORD_BITS),
    .SAMPLE_INT_BITS (SAMPLE_INT_BITS)
  ) u_back (
    .clk         (clk),
    .rst         (rst),
    .q_valid     (q_valid),
    .q_entry     (head_entry),
    .q_pop       (q_pop),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .out_word    (out_word),
    .is_forwarded(is_forwarded)
  );

endmodule

// ----- tb/sv/tb_top.sv -----
`timescale 1ns / 1ps

module tb_top;
  import qsm_pkg::*;

  localparam int VAL_W = PARAM_VALUE_BITS_DEF;
  localparam int PID_W = PARAM_ID_BITS_DEF;
  localparam int MOD_W = WORD_BITS - PID_W - VAL_W;
  localparam int SW = SAMPLE_WORD_BITS_DEF;
  localparam int SI = SAMPLE_INT_BITS_DEF;
  localparam int PID_PILOT = 3;
  localparam logic [MOD_W-1:0] END_ID = MOD_W'((1 << MODULE_ID_BITS_DEF) - 1);
  localparam logic [MOD_W-1:0] OWN_RST = MOD_W'(OWN_ID_RESET);
  localparam logic [PID_W-1:0] P_LEN = PID_W'(PID_DATA_LENGTH);
  localparam logic [PID_W-1:0] P_ORD = PID_W'(PID_ORDER);
  localparam logic [PID_W-1:0] P_CNT = PID_W'(PID_SYMBOL_COUNT);
  localparam logic [PID_W-1:0] P_PILOT = PID_W'(PID_PILOT);
  localparam int RANDOM_WORDS = 250;
  localparam int STALL_LIMIT = 3000;
  localparam int DRAIN_CYCLES = 4;

  typedef struct {
    logic [CFG_BITS-1:0] own_id;
    bit data_phase;
    logic [REG_BITS-1:0] frame_len;
    logic [REG_BITS-1:0] order;
    logic [REG_BITS-1:0] sym_count;
    logic [REG_BITS-1:0] pilot;
    logic [WORD_BITS-1:0] words_left;
    logic signed [2:0] last_re;
    logic signed [2:0] last_im;
  } mapper_state_t;

  typedef struct {
    logic [WORD_BITS-1:0] word;
    logic fwd;
  } out_beat_t;

  typedef enum int {RX_FREE, RX_LIGHT, RX_HALF, RX_HEAVY} rx_mode_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_ready;
  logic [WORD_BITS-1:0] in_word = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic [WORD_BITS-1:0] out_word;
  logic is_forwarded;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [CFG_BITS-1:0] cfg_data = '0;

  // word-level mirror of the block (checked side) and of the planned stream (stimulus side)
  mapper_state_t mirror;
  mapper_state_t plan;
  logic [WORD_BITS-1:0] in_words_q[$];
  out_beat_t awaited_q[$];
  int planned_words = 0;
  int out_beats = 0;
  int errors = 0;
  int idle_cycles = 0;
  logic in_fire = 1'b0;

  qam_symbol_mapper_with_param_header DUT (
    .clk(clk),
    .rst(rst),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .in_word(in_word),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_word(out_word),
    .is_forwarded(is_forwarded),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_data(cfg_data)
  );

  always #2 clk = ~clk;

  function automatic mapper_state_t reset_state();
    mapper_state_t s;
    s.own_id = OWN_ID_RESET;
    s.data_phase = 1'b0;
    s.frame_len = '0;
    s.order = '0;
    s.sym_count = '0;
    s.pilot = '0;
    s.words_left = '0;
    s.last_re = '0;
    s.last_im = '0;
    return s;
  endfunction

  // level v as v * 2^(SW-SI), wrapped to the sample width
  function automatic logic [SW-1:0] level_fixed(input logic signed [2:0] lvl);
    logic signed [SW-1:0] ext;
    ext = SW'(lvl);
    return ext <<< (SW - SI);
  endfunction

  // one input word through the mapper; returns 1 when it yields an output beat
  function automatic bit map_in_word(inout mapper_state_t s, input logic [WORD_BITS-1:0] w,
                                     output out_beat_t r);
    logic [MOD_W-1:0] mod_id;
    logic [PID_W-1:0] pid;
    logic [VAL_W-1:0] val;
    logic [WORD_BITS-1:0] q;
    bit fwd;
    r.word = w;
    r.fwd = 1'b1;
    if (!s.data_phase) begin
      mod_id = w[WORD_BITS-1 -: MOD_W];
      pid = w[VAL_W +: PID_W];
      val = w[VAL_W-1:0];
      fwd = 1'b0;
      if (mod_id == MOD_W'(s.own_id)) begin
        case (pid)
          P_LEN: s.frame_len = val;
          P_ORD: s.order = val;
          P_CNT: s.sym_count = val;
          P_PILOT: s.pilot = val;
          default: ;
        endcase
      end else begin
        fwd = 1'b1;
      end
      // end of header: a zero word count keeps the header phase
      if (mod_id == END_ID) begin
        s.words_left = WORD_BITS'(s.frame_len) * WORD_BITS'(s.sym_count);
        s.data_phase = (s.words_left != 0);
      end
      return fwd;
    end
    // data phase; an unsupported order keeps the last point
    if (s.order == ORDER_QAM16) begin
      case (w[1:0])
        2'd0: s.last_im = LVL_M3;
        2'd1: s.last_im = LVL_M1;
        2'd2: s.last_im = LVL_P3;
        default: s.last_im = LVL_P1;
      endcase
      q = w >> 2;
      s.last_re = (q == 0) ? LVL_M3 : (q == 1) ? LVL_M1 : (q == 2) ? LVL_P3 : LVL_P1;
    end else if (s.order == ORDER_QPSK) begin
      s.last_im = w[0] ? LVL_P1 : LVL_M1;
      s.last_re = ((w >> 1) == 0) ? LVL_M1 : LVL_P1;
    end
    r.word = '0;
    r.word[32 +: SW] = level_fixed(s.last_re);
    r.word[0 +: SW] = level_fixed(s.last_im);
    r.fwd = 1'b0;
    s.words_left = s.words_left - 1;
    if (s.words_left == 0) s.data_phase = 1'b0;
    return 1'b1;
  endfunction

  function automatic logic [WORD_BITS-1:0] hdr_word(input logic [MOD_W-1:0] mod_id,
                                                    input logic [PID_W-1:0] pid,
                                                    input logic [VAL_W-1:0] val);
    return {mod_id, pid, val};
  endfunction

  // module id that is neither ours nor the end marker; some are wide ids aliasing ours
  function automatic logic [MOD_W-1:0] other_module(input logic [CFG_BITS-1:0] own);
    logic [MOD_W-1:0] m;
    do begin
      case ($urandom_range(0, 3))
        0: m = MOD_W'($urandom);
        1: m = {16'($urandom_range(1, 65535)), own};
        default: m = MOD_W'($urandom_range(0, 254));
      endcase
    end while (m == MOD_W'(own) || m == END_ID);
    return m;
  endfunction

  function automatic logic [WORD_BITS-1:0] pick_symbol_index();
    case ($urandom_range(0, 9))
      0, 1, 2, 3, 4, 5: return WORD_BITS'($urandom_range(0, 15));
      6, 7: return WORD_BITS'($urandom_range(0, 3));
      8: return {$urandom, $urandom};
      default: return WORD_BITS'(1) << $urandom_range(0, WORD_BITS - 1);
    endcase
  endfunction

  function automatic logic [REG_BITS-1:0] pick_order();
    case ($urandom_range(0, 9))
      0, 1, 2, 3, 4: return ORDER_QAM16;
      5, 6, 7: return ORDER_QPSK;
      8: return '0;
      default: return $urandom;
    endcase
  endfunction

  function automatic logic [VAL_W-1:0] pick_count();
    return ($urandom_range(0, 9) == 0) ? '0 : VAL_W'($urandom_range(1, 4));
  endfunction

  task automatic feed_word(input logic [WORD_BITS-1:0] w);
    out_beat_t scratch;
    in_words_q.push_back(w);
    planned_words++;
    void'(map_in_word(plan, w, scratch));
  endtask

  // header word, followed by the data words it opens, if any
  task automatic push_header(input logic [WORD_BITS-1:0] w);
    feed_word(w);
    while (plan.data_phase) feed_word(pick_symbol_index());
  endtask

  // one header block with random content; some lack the end marker
  task automatic random_frame();
    logic [CFG_BITS-1:0] own;
    logic [MOD_W-1:0] own_m;
    logic [PID_W-1:0] end_pid;
    own = plan.own_id;
    own_m = MOD_W'(own);
    repeat ($urandom_range(0, 3))
      push_header(hdr_word(other_module(own), PID_W'($urandom), $urandom));
    if ($urandom_range(0, 3) == 0) push_header(hdr_word(own_m, P_PILOT, $urandom));
    if ($urandom_range(0, 4) == 0)
      push_header(hdr_word(own_m, PID_W'($urandom_range(4, 255)), $urandom));
    if ($urandom_range(0, 3) != 0) push_header(hdr_word(own_m, P_ORD, pick_order()));
    push_header(hdr_word(own_m, P_LEN, pick_count()));
    push_header(hdr_word(own_m, P_CNT, pick_count()));
    if ($urandom_range(0, 7) != 0) begin
      // with our id at all ones, the end marker must not load a huge length
      if (own_m == END_ID)
        end_pid = ($urandom_range(0, 1) == 1) ? P_PILOT : PID_W'($urandom_range(4, 255));
      else
        end_pid = PID_W'($urandom);
      push_header(hdr_word(END_ID, end_pid, $urandom));
    end
  endtask

  task automatic run_random(input int n_words);
    int goal;
    goal = planned_words + n_words;
    while (planned_words < goal) random_frame();
  endtask

  task automatic wait_drained();
    do @(posedge clk);
    while (in_words_q.size() != 0 || in_valid || awaited_q.size() != 0);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_own_id(input logic [CFG_BITS-1:0] id);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_data <= id;
    do @(posedge clk);
    while (!cfg_ready);
    @(negedge clk);
    cfg_valid <= 1'b0;
    plan.own_id = id;
  endtask

  task automatic directed_words();
    // order still at reset: points stay at level zero
    feed_word(hdr_word(OWN_RST, P_LEN, 32'd1));
    feed_word(hdr_word(OWN_RST, P_CNT, 32'd2));
    feed_word(hdr_word(END_ID, 8'h00, 32'h0));
    feed_word(64'h0);
    feed_word(64'hFFFF_FFFF_FFFF_FFFF);
    // 16-QAM, with forwarded, wide-id, ignored and pilot words in the header
    feed_word(hdr_word(OWN_RST, P_ORD, ORDER_QAM16));
    feed_word(hdr_word(OWN_RST, P_CNT, 32'd4));
    feed_word(hdr_word(24'h000001, 8'h5A, 32'hA5A5_A5A5));
    feed_word(hdr_word({16'h0001, OWN_ID_RESET}, P_LEN, 32'h1));
    feed_word(hdr_word(24'hFFFFFF, 8'hFF, 32'hFFFF_FFFF));
    feed_word(hdr_word(OWN_RST, 8'hFF, 32'hFFFF_FFFF));
    feed_word(hdr_word(OWN_RST, P_PILOT, 32'hFFFF_FFFF));
    feed_word(hdr_word(END_ID, 8'hFF, 32'hFFFF_FFFF));
    feed_word(64'd0);
    feed_word(64'd6);
    feed_word(64'd9);
    feed_word(64'hFFFF_FFFF_FFFF_FFFF);
    // QPSK
    feed_word(hdr_word(OWN_RST, P_ORD, ORDER_QPSK));
    feed_word(hdr_word(END_ID, 8'h00, 32'h0));
    feed_word(64'd0);
    feed_word(64'd1);
    feed_word(64'd2);
    feed_word(64'h8000_0000_0000_0003);
    // unsupported order repeats the last point
    feed_word(hdr_word(OWN_RST, P_ORD, 32'd8));
    feed_word(hdr_word(OWN_RST, P_CNT, 32'd1));
    feed_word(hdr_word(END_ID, 8'h00, 32'h0));
    feed_word(64'd7);
    // zero word count keeps the header phase
    feed_word(hdr_word(OWN_RST, P_LEN, 32'hFFFF_FFFF));
    feed_word(hdr_word(OWN_RST, P_CNT, 32'd0));
    feed_word(hdr_word(END_ID, 8'h00, 32'h0));
    feed_word(hdr_word(OWN_RST, P_LEN, 32'd0));
    feed_word(hdr_word(OWN_RST, P_CNT, 32'hFFFF_FFFF));
    feed_word(hdr_word(END_ID, 8'h00, 32'h0));
  endtask

  // sequencer: reset, directed words, then random phases under several own ids
  initial begin
    logic [CFG_BITS-1:0] own_ids [5];
    own_ids[0] = 8'h00;
    own_ids[1] = 8'hFF;
    own_ids[2] = CFG_BITS'($urandom_range(1, 254));
    own_ids[3] = OWN_ID_RESET;
    own_ids[4] = CFG_BITS'($urandom_range(1, 254));
    mirror = reset_state();
    plan = reset_state();
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    directed_words();
    run_random(RANDOM_WORDS);
    wait_drained();
    foreach (own_ids[i]) begin
      write_own_id(own_ids[i]);
      if (MOD_W'(own_ids[i]) == END_ID) begin
        // every word for us is also an end marker
        push_header(hdr_word(END_ID, P_CNT, 32'd0));
        push_header(hdr_word(END_ID, P_LEN, 32'd1));
        push_header(hdr_word(END_ID, P_CNT, 32'd2));
      end
      run_random(RANDOM_WORDS);
      wait_drained();
    end
    if (errors == 0)
      $display("tb_top: PASS");
    else
      $display("tb_top: FAIL");
    $finish;
  end

  // input driver: bursts of beats with random gaps
  int burst_left = 0;
  int gap_left = 0;
  always @(negedge clk) begin
    if (!rst && (!in_valid || in_fire)) begin
      if (gap_left > 0) begin
        gap_left--;
        in_valid <= 1'b0;
      end else if (in_words_q.size() > 0) begin
        in_valid <= 1'b1;
        in_word <= in_words_q.pop_front();
        if (burst_left <= 1) begin
          burst_left = $urandom_range(1, ($urandom_range(0, 4) == 0) ? 60 : 12);
          gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
        end else begin
          burst_left--;
        end
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // output ready: random stall modes, plus long hold-offs to back up the input
  rx_mode_t stall_mode = RX_FREE;
  int mode_left = 0;
  int hold_left = 0;
  int next_hold_at = 400;
  always @(negedge clk) begin
    if (rst) begin
      out_ready <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left--;
      out_ready <= 1'b0;
    end else if (out_beats >= next_hold_at) begin
      next_hold_at = (next_hold_at == 400) ? 1000 : 32'h7FFF_FFFF;
      hold_left = 150;
      out_ready <= 1'b0;
    end else begin
      if (mode_left == 0) begin
        stall_mode = rx_mode_t'($urandom_range(0, 3));
        mode_left = $urandom_range(10, 80);
      end else begin
        mode_left--;
      end
      case (stall_mode)
        RX_FREE: out_ready <= 1'b1;
        RX_LIGHT: out_ready <= ($urandom_range(0, 3) != 0);
        RX_HALF: out_ready <= ($urandom_range(0, 1) == 1);
        default: out_ready <= ($urandom_range(0, 3) == 0);
      endcase
    end
  end

  // monitor: predict on accepted input beats, check accepted output beats, watchdog
  always @(posedge clk) begin
    out_beat_t want;
    if (!rst) begin
      in_fire <= in_valid && in_ready;
      if (cfg_valid && cfg_ready) mirror.own_id = cfg_data;
      if (in_valid && in_ready) begin
        if (map_in_word(mirror, in_word, want)) awaited_q.push_back(want);
      end
      if (out_valid && out_ready) begin
        out_beats++;
        if (awaited_q.size() == 0) begin
          $error("unexpected output beat: out_word %h is_forwarded %b", out_word, is_forwarded);
          errors++;
        end else begin
          want = awaited_q.pop_front();
          if (out_word !== want.word) begin
            $error("out_word: expected %h, got %h", want.word, out_word);
            errors++;
          end
          if (is_forwarded !== want.fwd) begin
            $error("is_forwarded: expected %b, got %b", want.fwd, is_forwarded);
            errors++;
          end
        end
      end
      if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
        idle_cycles = 0;
      else
        idle_cycles++;
      if (idle_cycles >= STALL_LIMIT) begin
        $display("tb_top: FAIL");
        $finish;
      end
    end
  end

endmodule
